// ----- rtl/core/tkst_pkg.sv -----
`default_nettype none

package tkst_pkg;

    // entry status codes
    localparam logic [2:0] ST_EMPTY     = 3'd0;
    localparam logic [2:0] ST_CANDIDATE = 3'd1;
    localparam logic [2:0] ST_PINNED    = 3'd3;
    localparam logic [2:0] ST_SEALED    = 3'd4;

    // highest score, never evicted
    localparam logic signed [15:0] SCORE_TOP = 16'sh7FFF;

    // request codes
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_ARCHIVE = 1'b1;

    // register map
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_MIN_SCORE = '0;

    // one stored entry
    typedef struct packed {
        logic [15:0]        id;
        logic signed [15:0] score;
        logic [2:0]         status;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_run;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } status_t;

    // pinned and sealed entries survive archive and eviction
    function automatic logic is_kept(input logic [2:0] status);
        return (status == ST_PINNED) || (status == ST_SEALED);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tkst_ram.sv -----
`default_nettype none

module tkst_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tkst_ctrl.sv -----
`default_nettype none

module tkst_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire tkst_pkg::status_t  status,
    output tkst_pkg::cmd_t          cmd
);

    typedef enum logic [1:0] {
        IDLE,
        DECIDE,
        SCAN,
        COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = DECIDE;
                end
            end
            DECIDE:
            begin
                if (status.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = SCAN;
                end
                else
                begin
                    state_next = COMMIT;
                end
            end
            SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = COMMIT;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            COMMIT:
            begin
                // wait until the output register can take the word
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tkst_dp.sv -----
`default_nettype none

module tkst_dp #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tkst_pkg::cmd_t     cmd,
    output tkst_pkg::status_t       status,
    input  wire logic signed [15:0] min_score,
    input  wire logic               req_type,
    input  wire logic [15:0]        entry_id,
    input  wire logic signed [15:0] entry_score,
    input  wire logic [2:0]         entry_status,
    output logic                    accepted,
    output logic [2:0]              slot,
    output logic [3:0]              entry_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // captured request
    logic                    archive_reg;
    tkst_pkg::entry_t        req_reg;

    // table fill and scan state
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        rd_ptr_reg;
    logic [CNT_W-1:0]        wr_ptr_reg;
    logic                    pend_valid_reg;
    logic signed [15:0]      low_score_reg;
    logic [IDX_W-1:0]        low_idx_reg;
    logic                    found_reg;

    // output word
    logic                    accepted_reg;
    logic [2:0]              slot_reg;
    logic [3:0]              entry_count_reg;

    logic                    pass_min;
    logic                    not_full;
    logic                    issue;
    tkst_pkg::entry_t        rd_entry;
    logic [tkst_pkg::ENTRY_W-1:0] rd_data;
    logic                    pack_we;
    logic                    ins_we;
    logic [IDX_W-1:0]        ins_addr;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [tkst_pkg::ENTRY_W-1:0] ram_wdata;
    logic                    better;
    logic [CNT_W-1:0]        count_next;

    assign pass_min = ($signed(req_reg.score) >= $signed(min_score));
    assign not_full = (count_reg < DEPTH_CNT);
    assign issue    = cmd.scan_run && (rd_ptr_reg < count_reg);
    assign rd_entry = tkst_pkg::entry_t'(rd_data);

    assign status.need_scan = archive_reg || (pass_min && !not_full);
    assign status.scan_done = !pend_valid_reg && (rd_ptr_reg >= count_reg);

    // compaction write of a kept entry
    assign pack_we = cmd.scan_run && pend_valid_reg && archive_reg
                     && tkst_pkg::is_kept(rd_entry.status);

    // insert write: append, or replace the lowest evictable entry
    assign better   = found_reg && ($signed(req_reg.score) > $signed(low_score_reg));
    assign ins_we   = cmd.commit && !archive_reg && pass_min && (not_full || better);
    assign ins_addr = not_full ? count_reg[IDX_W-1:0] : low_idx_reg;

    assign ram_we    = pack_we || ins_we;
    assign ram_waddr = pack_we ? wr_ptr_reg[IDX_W-1:0] : ins_addr;
    assign ram_wdata = pack_we ? rd_data : req_reg;

    always_comb
    begin
        if (archive_reg)
        begin
            count_next = wr_ptr_reg;
        end
        else if (ins_we && not_full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    tkst_ram #(
        .WIDTH (tkst_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (rd_ptr_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    // request capture, empty status becomes candidate
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            archive_reg  <= (req_type == tkst_pkg::REQ_ARCHIVE);
            req_reg.id    <= entry_id;
            req_reg.score <= entry_score;
            if (entry_status == tkst_pkg::ST_EMPTY)
            begin
                req_reg.status <= tkst_pkg::ST_CANDIDATE;
            end
            else
            begin
                req_reg.status <= entry_status;
            end
        end
    end

    // serial walk over the table, one read issued per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                rd_ptr_reg     <= '0;
                wr_ptr_reg     <= '0;
                pend_valid_reg <= 1'b0;
                found_reg      <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                pend_valid_reg <= issue;
                if (issue)
                begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                end
                if (pack_we)
                begin
                    wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
                end
                if (pend_valid_reg && !archive_reg
                    && !tkst_pkg::is_kept(rd_entry.status)
                    && ($signed(rd_entry.score) < $signed(low_score_reg)))
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    // lowest evictable score, earliest index wins ties
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            low_score_reg <= tkst_pkg::SCORE_TOP;
            low_idx_reg   <= '0;
        end
        else if (cmd.scan_run && pend_valid_reg && !archive_reg
                 && !tkst_pkg::is_kept(rd_entry.status)
                 && ($signed(rd_entry.score) < $signed(low_score_reg)))
        begin
            low_score_reg <= rd_entry.score;
            low_idx_reg   <= IDX_W'(rd_ptr_reg - CNT_W'(1));
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            accepted_reg    <= archive_reg || ins_we;
            slot_reg        <= ins_we ? 3'(ins_addr) : 3'd0;
            entry_count_reg <= 4'(count_next);
        end
    end

    assign accepted    = accepted_reg;
    assign slot        = slot_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/top_k_score_table_with_pinning.sv -----
// flow: an append, or an insert below min_score, goes from DECIDE straight to COMMIT;
// an insert into a full table and an archive first run the serial walk through the
// single-read-port table ram, which reads every stored entry
// throughput: one request at a time; the next word is accepted only after the last
// is committed, which waits while a stalled result still holds the output register
// reset: table empty, min_score 0, no output word pending; no clearing pass
`default_nettype none

module top_k_score_table_with_pinning #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tkst_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [15:0]                   entry_id,
    input  wire logic signed [15:0]            entry_score,
    input  wire logic [2:0]                    entry_status,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               accepted,
    output logic [2:0]                         slot,
    output logic [3:0]                         entry_count
);

    logic signed [15:0]  min_score_reg;
    logic                cfg_sel;
    tkst_pkg::cmd_t      cmd;
    tkst_pkg::status_t   status;

    // register file
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[tkst_pkg::ADDR_W-1:2] == tkst_pkg::REG_MIN_SCORE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_score_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            min_score_reg <= pwdata[15:0];
        end
    end

    assign prdata = cfg_sel ? {{16{min_score_reg[15]}}, min_score_reg} : 32'd0;

    tkst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tkst_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .min_score    (min_score_reg),
        .req_type     (req_type),
        .entry_id     (entry_id),
        .entry_score  (entry_score),
        .entry_status (entry_status),
        .accepted     (accepted),
        .slot         (slot),
        .entry_count  (entry_count)
    );

    // a request in work blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in work");

    // a result is committed only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid && out_stall))
        else $error("result committed over a pending output word");

    // a rejected insert reports slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (slot == 3'd0))
        else $error("rejected request with nonzero slot");

endmodule

`default_nettype wire

// ----- test/top_k_score_table_with_pinning_test.sv -----
`timescale 1ns / 1ps

// one expected result word
typedef struct packed {
    logic       ok;
    logic [2:0] slot;
    logic [3:0] count;
} table_reply_t;

// shadow copy of the score table, predicts every result word
class table_tracker;
    tkst_pkg::entry_t   rows [8];
    int unsigned        fill;
    logic signed [15:0] floor_score;
    table_reply_t       reply_q [$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        appends;
    int unsigned        evictions;
    int unsigned        rejects;
    int unsigned        archives;

    function new();
        fill        = 0;
        floor_score = '0;
        errors      = 0;
        checked     = 0;
        appends     = 0;
        evictions   = 0;
        rejects     = 0;
        archives    = 0;
    endfunction

    // pinned and sealed rows are never dropped or replaced
    function bit stays(logic [2:0] st);
        return (st == tkst_pkg::ST_PINNED) || (st == tkst_pkg::ST_SEALED);
    endfunction

    function void set_floor(logic signed [15:0] v);
        floor_score = v;
    endfunction

    function int unsigned held_count();
        int unsigned n;
        n = 0;
        for (int i = 0; i < fill; i++)
            if (stays(rows[i].status))
                n++;
        return n;
    endfunction

    function int unsigned waiting();
        return reply_q.size();
    endfunction

    task flag(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // apply one accepted request to the shadow table
    function void take_request(logic kind, logic [15:0] id, logic signed [15:0] score,
                               logic [2:0] st);
        table_reply_t     r;
        tkst_pkg::entry_t e;
        int unsigned      w;
        int               low_idx;
        int               low_score;
        bit               found;
        r.ok   = 1'b0;
        r.slot = '0;
        if (kind == tkst_pkg::REQ_ARCHIVE)
        begin
            // compact, keeping held rows in order
            w = 0;
            for (int i = 0; i < fill; i++)
            begin
                if (stays(rows[i].status))
                begin
                    rows[w] = rows[i];
                    w++;
                end
            end
            fill = w;
            r.ok = 1'b1;
            archives++;
        end
        else if (score >= floor_score)
        begin
            e.id     = id;
            e.score  = score;
            e.status = (st == tkst_pkg::ST_EMPTY) ? tkst_pkg::ST_CANDIDATE : st;
            if (fill < 8)
            begin
                rows[fill] = e;
                r.slot     = 3'(fill);
                r.ok       = 1'b1;
                fill++;
                appends++;
            end
            else
            begin
                // earliest lowest evictable row, top score never chosen
                found     = 1'b0;
                low_idx   = 0;
                low_score = 32767;
                for (int i = 0; i < fill; i++)
                begin
                    if (!stays(rows[i].status) && ($signed(rows[i].score) < low_score))
                    begin
                        low_score = $signed(rows[i].score);
                        low_idx   = i;
                        found     = 1'b1;
                    end
                end
                if (found && (int'(score) > low_score))
                begin
                    rows[low_idx] = e;
                    r.slot        = 3'(low_idx);
                    r.ok          = 1'b1;
                    evictions++;
                end
            end
        end
        if (!r.ok)
            rejects++;
        r.count = 4'(fill);
        reply_q.push_back(r);
    endfunction

    // compare one result word with the oldest prediction
    task match_reply(logic acc, logic [2:0] slot, logic [3:0] cnt);
        table_reply_t r;
        if (reply_q.size() == 0)
        begin
            flag("unexpected result word", 1, 0);
            return;
        end
        r = reply_q.pop_front();
        checked++;
        if (acc !== r.ok)
            flag("accepted", acc, r.ok);
        if (slot !== r.slot)
            flag("slot", slot, r.slot);
        if (cnt !== r.count)
            flag("entry_count", cnt, r.count);
    endtask
endclass

module top_k_score_table_with_pinning_test;

    localparam int DEPTH      = 8;
    localparam int SETTLE     = 16;
    localparam int IDLE_LIMIT = 2000;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [tkst_pkg::ADDR_W-1:0] paddr        = '0;
    logic [31:0]                 pwdata       = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic                        req_type     = tkst_pkg::REQ_INSERT;
    logic [15:0]                 entry_id     = '0;
    logic signed [15:0]          entry_score  = '0;
    logic [2:0]                  entry_status = tkst_pkg::ST_EMPTY;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic                        accepted;
    logic [2:0]                  slot;
    logic [3:0]                  entry_count;

    table_tracker book = new();
    bit           steady = 1'b0;
    int unsigned  held_cap = 3;
    int unsigned  settings = 1;
    int unsigned  idle_run = 0;

    top_k_score_table_with_pinning #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .entry_id     (entry_id),
        .entry_score  (entry_score),
        .entry_status (entry_status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .slot         (slot),
        .entry_count  (entry_count)
    );

    always #5 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.match_reply(accepted, slot, entry_count);
    end

    // receiver backpressure in random bursts
    initial
    begin
        int n;
        @(posedge clk);
        forever
        begin
            if (!steady && ($urandom_range(0, 2) == 0))
            begin
                n = $urandom_range(1, 19);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            n = $urandom_range(1, 25);
            out_stall <= 1'b0;
            repeat (n) @(posedge clk);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= IDLE_LIMIT)
        begin
            $display("%0t timeout: no handshake for %0d cycles", $time, idle_run);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // write min_score, then read it back
    task automatic write_floor(logic signed [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {tkst_pkg::REG_MIN_SCORE, 2'b00};
        pwdata  <= {{16{v[15]}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        book.set_floor(v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== v)
            book.flag("min_score readback", prdata[15:0], v);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop sending and wait for every outstanding result word
    task automatic drain();
        in_valid <= 1'b0;
        while (book.waiting() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic new_setting(logic signed [15:0] v);
        drain();
        repeat (SETTLE) @(posedge clk);
        write_floor(v);
        settings++;
    endtask

    // send one request word, with an optional gap in front
    task automatic push_word(logic kind, logic [15:0] id, logic signed [15:0] score,
                             logic [2:0] st);
        int n;
        if (!steady && ($urandom_range(0, 3) == 0))
        begin
            n = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        entry_id     <= id;
        entry_score  <= score;
        entry_status <= st;
        do
            @(posedge clk);
        while (in_stall);
        book.take_request(kind, id, score, st);
    endtask

    task automatic insert(logic [15:0] id, logic signed [15:0] score, logic [2:0] st);
        push_word(tkst_pkg::REQ_INSERT, id, score, st);
    endtask

    task automatic archive();
        push_word(tkst_pkg::REQ_ARCHIVE, 16'($urandom), 16'($urandom), 3'($urandom));
    endtask

    // random request, scores partly clustered around the current floor, partly extreme or uniform
    task automatic rand_word();
        logic               kind;
        logic [15:0]        id;
        logic signed [15:0] sc;
        logic [2:0]         st;
        int                 m;
        int                 v;
        kind = ($urandom_range(0, 11) == 0) ? tkst_pkg::REQ_ARCHIVE : tkst_pkg::REQ_INSERT;
        id   = 16'($urandom);
        m    = book.floor_score;
        case ($urandom_range(0, 15))
            0:       sc = tkst_pkg::SCORE_TOP;
            1:       sc = 16'sh8000;
            2:       sc = (m > -32768) ? 16'(m - 1) : 16'(m);
            3:       sc = 16'(m);
            4, 5, 6, 7, 8:
                     sc = 16'($urandom);
            default:
            begin
                v  = m + $urandom_range(0, 400);
                sc = (v > 32767) ? tkst_pkg::SCORE_TOP : 16'(v);
            end
        endcase
        st = 3'($urandom_range(0, 7));
        // held rows are permanent, so keep room for churn
        if ((book.held_count() >= held_cap) &&
            ((st == tkst_pkg::ST_PINNED) || (st == tkst_pkg::ST_SEALED)))
            st = st + 3'd2;
        push_word(kind, id, sc, st);
        if (!steady && ($urandom_range(0, 49) == 0))
            drain();
    endtask

    initial
    begin
        logic signed [15:0] floors [7];
        int                 counts [7];
        int                 caps   [7];
        floors = '{16'sh8000, 16'sh0000, -16'sd300, 16'sh0000, tkst_pkg::SCORE_TOP,
                   16'sh0000, 16'sh8000};
        counts = '{200, 200, 200, 200, 60, 200, 240};
        caps   = '{3, 3, 4, 4, 5, 5, 6};
        floors[1] = 16'($urandom);
        floors[5] = 16'($urandom);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset floor of zero
        insert(16'h0000, -16'sd1, tkst_pkg::ST_EMPTY);
        insert(16'hFFFF, 16'sd0, tkst_pkg::ST_EMPTY);

        // lowest floor: fill with every status, then evict
        new_setting(16'sh8000);
        insert(16'h0001, 16'sh8000, tkst_pkg::ST_CANDIDATE);
        insert(16'h0002, tkst_pkg::SCORE_TOP, 3'd2);
        insert(16'h0003, 16'sd5, tkst_pkg::ST_PINNED);
        insert(16'h0004, 16'sd100, tkst_pkg::ST_SEALED);
        insert(16'h0005, -16'sd5, 3'd5);
        insert(16'h0006, 16'sd7, 3'd6);
        insert(16'h0007, 16'sd20, 3'd7);
        // equal to the lowest score: appended, as the table is not yet full
        insert(16'h0008, 16'sh8000, tkst_pkg::ST_EMPTY);
        insert(16'h0009, -16'sd100, 3'd2);
        insert(16'h000A, tkst_pkg::SCORE_TOP, tkst_pkg::ST_CANDIDATE);
        archive();
        archive();
        // only top scores besides held rows: nothing evictable
        insert(16'h1111, tkst_pkg::SCORE_TOP, tkst_pkg::ST_CANDIDATE);
        insert(16'h2222, tkst_pkg::SCORE_TOP, 3'd2);
        insert(16'h3333, tkst_pkg::SCORE_TOP, 3'd5);
        insert(16'h4444, tkst_pkg::SCORE_TOP, 3'd6);
        insert(16'h5555, tkst_pkg::SCORE_TOP, 3'd7);
        insert(16'h6666, tkst_pkg::SCORE_TOP, tkst_pkg::ST_EMPTY);
        insert(16'hFFFF, tkst_pkg::SCORE_TOP, tkst_pkg::ST_PINNED);
        archive();

        // highest floor
        new_setting(tkst_pkg::SCORE_TOP);
        insert(16'hA5A5, 16'sh7FFE, tkst_pkg::ST_CANDIDATE);
        insert(16'h5A5A, tkst_pkg::SCORE_TOP, tkst_pkg::ST_EMPTY);
        archive();

        // random phases over several floors
        for (int p = 0; p < 7; p++)
        begin
            new_setting(floors[p]);
            held_cap = caps[p];
            if (p == 6)
                steady = 1'b1;
            for (int k = 0; k < counts[p]; k++)
                rand_word();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d appends, %0d evictions, %0d rejections, %0d archives",
                 book.appends, book.evictions, book.rejects, book.archives);
        $display("over %0d min_score settings, %0d result words checked",
                 settings, book.checked);
        if (book.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
